// File: hdl/gplf_pkg.sv
// gplf_pkg: shared sizes, codes and types for the grid local peak finder.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package gplf_pkg;

    // Grid capacity and sample width.
    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int SAMPLE_BITS = 16;

    // Derived widths.
    localparam int COL_W = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;

    // Fixed widths of registers and result fields.
    localparam int DIM_W       = 11;
    localparam int OUT_ROW_W   = 10;
    localparam int OUT_COL_W   = 10;
    localparam int TOTAL_W     = 21;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Result queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Result kinds.
    localparam logic KIND_PEAK  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    // Register indexes (paddr[2]).
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);

    // One line store entry: the row two above and the row above.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] prev2;
        logic [SAMPLE_BITS-1:0] prev;
    } t_line_word;

    // One result transaction.
    typedef struct packed {
        logic                 kind;
        logic [OUT_ROW_W-1:0] peak_row;
        logic [OUT_COL_W-1:0] peak_col;
        logic [TOTAL_W-1:0]   peak_total;
        logic                 last;
    } t_result;

    // Results offered to the queue in one cycle: up to two, slot0 first.
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

    // Cell waiting to be judged.
    typedef struct packed {
        logic                   has_left;
        logic                   has_right;
        logic                   has_up;
        logic                   has_down;
        logic                   final_col;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic [SAMPLE_BITS-1:0] centre;
        logic [SAMPLE_BITS-1:0] up;
        logic [SAMPLE_BITS-1:0] down;
    } t_judge;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (32'(v) > hi) begin
            r = DIM_W'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [OUT_ROW_W-1:0] fit_row(input logic [ROW_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_ROW_W-1:0];
    endfunction

    function automatic logic [OUT_COL_W-1:0] fit_col(input logic [COL_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_COL_W-1:0];
    endfunction

endpackage

// File: hdl/grid_local_peak_finder.sv
// grid_local_peak_finder: streaming four-neighbour peak finder over a raster grid.
// Depends on gplf_pkg and instantiates gplf_res_queue.
//
//   Channel  | Direction | Handshake                  | Payload
//   ---------+-----------+----------------------------+--------------------------------------
//   input    | in        | i_in_valid / o_in_ready    | i_opcode, i_sample
//   result   | out       | o_out_valid / i_out_ready  | o_kind, o_peak_row, o_peak_col,
//            |           |                            | o_peak_total, o_last
//   config   | in        | APB psel/penable/pwrite    | paddr, pwdata, prdata (pready = 1)
//
// Cycles: one input transaction per clock while o_in_ready is high. A cell is judged in
// the cycle after the transaction that completes its neighbourhood, and its results
// then go into a four-entry queue that feeds the output.
// Reset is synchronous and active low; it clears the counters, the pipeline and the
// queue. The line store itself is not cleared: each frame writes row 0 before reading.
// Stalls: o_in_ready drops only while a judged cell waits for two free queue slots,
// which happens when the result side is backpressured.
module grid_local_peak_finder (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_opcode,
    input  logic signed [gplf_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_kind,
    output logic [gplf_pkg::OUT_ROW_W-1:0]        o_peak_row,
    output logic [gplf_pkg::OUT_COL_W-1:0]        o_peak_col,
    output logic [gplf_pkg::TOTAL_W-1:0]          o_peak_total,
    output logic                                  o_last,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [gplf_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [gplf_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [gplf_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers. The raw values are read back; the clamped
    // copies drive the datapath. Any write restarts the frame.
    // ------------------------------------------------------------------
    logic [gplf_pkg::DIM_W-1:0] r_grid_rows;
    logic [gplf_pkg::DIM_W-1:0] r_grid_cols;
    logic [gplf_pkg::DIM_W-1:0] r_rows_eff;
    logic [gplf_pkg::DIM_W-1:0] r_cols_eff;
    logic                       cfg_wr;
    logic                       cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= gplf_pkg::DIM_MIN;
            r_grid_cols <= gplf_pkg::DIM_MIN;
            r_rows_eff  <= gplf_pkg::DIM_MIN;
            r_cols_eff  <= gplf_pkg::DIM_MIN;
        end else if (cfg_wr) begin
            case (cfg_idx)
                gplf_pkg::REG_ROWS: begin
                    r_grid_rows <= pwdata[gplf_pkg::DIM_W-1:0];
                    r_rows_eff  <= gplf_pkg::clamp_dim(pwdata[gplf_pkg::DIM_W-1:0],
                                                       gplf_pkg::MAX_ROWS);
                end
                gplf_pkg::REG_COLS: begin
                    r_grid_cols <= pwdata[gplf_pkg::DIM_W-1:0];
                    r_cols_eff  <= gplf_pkg::clamp_dim(pwdata[gplf_pkg::DIM_W-1:0],
                                                       gplf_pkg::MAX_COLS);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            gplf_pkg::REG_ROWS: prdata = gplf_pkg::APB_DATA_W'(r_grid_rows);
            gplf_pkg::REG_COLS: prdata = gplf_pkg::APB_DATA_W'(r_grid_cols);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input stage: position counters, line store read-modify-write.
    // The store is read one column ahead, so the word for the current
    // column is already in the read register when its transaction arrives.
    // At the last column the look-ahead wraps to column 0 of the next row.
    // ------------------------------------------------------------------
    logic [gplf_pkg::DIM_W-1:0] r_row;
    logic [gplf_pkg::COL_W-1:0] r_col;

    gplf_pkg::t_line_word       r_line_mem [gplf_pkg::MAX_COLS];
    gplf_pkg::t_line_word       r_line_q;
    gplf_pkg::t_line_word       mem_wdata;

    logic                       in_fire;
    logic                       is_flush;
    logic                       row_full;
    logic                       take;
    logic                       judge_en;
    logic                       last_col;
    logic [gplf_pkg::COL_W-1:0] col;
    logic [gplf_pkg::COL_W-1:0] col_inc;
    logic [gplf_pkg::COL_W-1:0] rd_addr;
    logic [31:0]                jr_wide;
    logic [gplf_pkg::ROW_W-1:0] jr;
    logic                       mem_we;

    gplf_pkg::t_judge           r_s1;
    logic                       r_s1_valid;
    logic                       s1_adv;

    assign in_fire  = i_in_valid && o_in_ready;
    assign is_flush = (i_opcode == gplf_pkg::OP_FLUSH);
    assign row_full = (32'(r_row) >= 32'(r_rows_eff));
    // Samples after the grid is complete, and flushes before it, are dropped.
    assign take     = in_fire && (is_flush ? row_full : !row_full);
    assign judge_en = (r_row != '0);
    assign col      = (32'(r_col) >= 32'(r_cols_eff)) ? '0 : r_col;
    assign col_inc  = col + gplf_pkg::COL_W'(1);
    assign last_col = (32'(col) + 32'd1 >= 32'(r_cols_eff));
    assign rd_addr  = last_col ? '0 : col_inc;
    assign jr_wide  = is_flush ? 32'(r_rows_eff) - 32'd1 : 32'(r_row) - 32'd1;
    assign jr       = jr_wide[gplf_pkg::ROW_W-1:0];
    assign mem_we   = take && !is_flush;

    // Shift the column down one row: old "row above" becomes "two above".
    assign mem_wdata.prev2 = r_line_q.prev;
    assign mem_wdata.prev  = i_sample;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_mem[col] <= mem_wdata;
        end
        if (take) begin
            r_line_q <= r_line_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (cfg_wr) begin
            r_row <= '0;
            r_col <= '0;
        end else if (take) begin
            if (last_col) begin
                r_col <= '0;
                if (is_flush) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + gplf_pkg::DIM_W'(1);
                end
            end else begin
                r_col <= col_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Judge stage. The right neighbour is the look-ahead word, which stays
    // in the read register because no new transaction is taken while this
    // stage holds.
    // ------------------------------------------------------------------
    logic                               queue_room;
    logic [gplf_pkg::SAMPLE_BITS-1:0]   r_left;
    logic [gplf_pkg::TOTAL_W-1:0]       r_peak_cnt;
    logic [gplf_pkg::TOTAL_W-1:0]       total;
    logic                               is_peak;
    gplf_pkg::t_result                  res_peak;
    gplf_pkg::t_result                  res_total;
    gplf_pkg::t_push                    push;

    assign s1_adv     = r_s1_valid && queue_room;
    assign o_in_ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= take && judge_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && take && judge_en) begin
            r_s1.has_left  <= (col != '0);
            r_s1.has_right <= !last_col;
            r_s1.has_up    <= (jr != '0);
            r_s1.has_down  <= !is_flush;
            r_s1.final_col <= is_flush && last_col;
            r_s1.row       <= jr;
            r_s1.col       <= col;
            r_s1.centre    <= r_line_q.prev;
            r_s1.up        <= r_line_q.prev2;
            r_s1.down      <= i_sample;
        end
    end

    // Ties do not disqualify: only a strictly greater neighbour does.
    always_comb begin
        is_peak = 1'b1;
        if (r_s1.has_left && ($signed(r_s1.centre) < $signed(r_left))) begin
            is_peak = 1'b0;
        end
        if (r_s1.has_right && ($signed(r_s1.centre) < $signed(r_line_q.prev))) begin
            is_peak = 1'b0;
        end
        if (r_s1.has_up && ($signed(r_s1.centre) < $signed(r_s1.up))) begin
            is_peak = 1'b0;
        end
        if (r_s1.has_down && ($signed(r_s1.centre) < $signed(r_s1.down))) begin
            is_peak = 1'b0;
        end
    end

    assign total = r_peak_cnt + gplf_pkg::TOTAL_W'(is_peak);

    always_comb begin
        res_peak.kind       = gplf_pkg::KIND_PEAK;
        res_peak.peak_row   = gplf_pkg::fit_row(r_s1.row);
        res_peak.peak_col   = gplf_pkg::fit_col(r_s1.col);
        res_peak.peak_total = '0;
        res_peak.last       = 1'b0;

        res_total.kind       = gplf_pkg::KIND_TOTAL;
        res_total.peak_row   = '0;
        res_total.peak_col   = '0;
        res_total.peak_total = total;
        res_total.last       = 1'b1;

        push.slot0 = is_peak ? res_peak : res_total;
        push.slot1 = res_total;
        if (s1_adv) begin
            push.count = 2'(is_peak) + 2'(r_s1.final_col);
        end else begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_cnt <= '0;
        end else if (cfg_wr) begin
            r_peak_cnt <= '0;
        end else if (s1_adv) begin
            if (r_s1.final_col) begin
                r_peak_cnt <= '0;
            end else begin
                r_peak_cnt <= total;
            end
        end
    end

    // The judged centre becomes the left neighbour of the next column.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_left <= r_s1.centre;
        end
    end

    // ------------------------------------------------------------------
    // Result queue and output.
    // ------------------------------------------------------------------
    gplf_pkg::t_result head;

    gplf_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (queue_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (head)
    );

    assign o_kind       = head.kind;
    assign o_peak_row   = head.peak_row;
    assign o_peak_col   = head.peak_col;
    assign o_peak_total = head.peak_total;
    assign o_last       = head.last;

endmodule

// File: hdl/gplf_res_queue.sv
// gplf_res_queue: small result queue that takes up to two results per cycle.
// Depends on gplf_pkg for the result types and the queue depth.
module gplf_res_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gplf_pkg::t_push  i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output gplf_pkg::t_result o_head
);

    gplf_pkg::t_result               r_slots [gplf_pkg::QUEUE_DEPTH];
    logic [gplf_pkg::QPTR_W-1:0]     r_wr;
    logic [gplf_pkg::QPTR_W-1:0]     r_rd;
    logic [gplf_pkg::QCNT_W-1:0]     r_count;
    logic [gplf_pkg::QCNT_W-1:0]     n_count;
    logic [gplf_pkg::QPTR_W-1:0]     wr_next;
    logic                            pop;

    assign pop     = (r_count != '0) && i_ready;
    assign o_valid = (r_count != '0);
    assign o_head  = r_slots[r_rd];
    // Room for the largest push of one cycle.
    assign o_room  = (32'(r_count) <= gplf_pkg::QUEUE_DEPTH - 2);
    assign wr_next = r_wr + gplf_pkg::QPTR_W'(1);
    assign n_count = r_count + gplf_pkg::QCNT_W'(i_push.count)
                     - gplf_pkg::QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + gplf_pkg::QPTR_W'(i_push.count);
            r_rd    <= r_rd + gplf_pkg::QPTR_W'(pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_slots[r_wr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_slots[wr_next] <= i_push.slot1;
        end
    end

endmodule

// File: hdl/gplf_checker.sv
// gplf_checker: port-level assertions for grid_local_peak_finder, bound to the top level.
// Depends on gplf_pkg for field widths and result kind codes.
module gplf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic                            o_kind,
    input logic [gplf_pkg::OUT_ROW_W-1:0]  o_peak_row,
    input logic [gplf_pkg::OUT_COL_W-1:0]  o_peak_col,
    input logic [gplf_pkg::TOTAL_W-1:0]    o_peak_total,
    input logic                            o_last
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid &&
            $stable({o_kind, o_peak_row, o_peak_col, o_peak_total, o_last}))
        else $error("result changed while stalled");

    // The count result closes the frame and carries no coordinate.
    a_total_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == gplf_pkg::KIND_TOTAL) |->
            o_last && (o_peak_row == '0) && (o_peak_col == '0))
        else $error("malformed count result");

    // A peak coordinate never ends the frame and carries no count.
    a_peak_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == gplf_pkg::KIND_PEAK) |->
            !o_last && (o_peak_total == '0))
        else $error("malformed peak result");

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind grid_local_peak_finder gplf_checker u_gplf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_peak_row   (o_peak_row),
    .o_peak_col   (o_peak_col),
    .o_peak_total (o_peak_total),
    .o_last       (o_last)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for grid_local_peak_finder: streams grids and flush columns,
// predicts every peak coordinate and frame total, and compares each result transaction.
// Depends on gplf_pkg for sizes, codes and the result record; drives the block as u_top.

// Tracks what the peak finder must produce: its own copy of the size registers, the two
// line stores, the three-sample window and the counters, plus the results still owed.
class peak_ledger;
    logic [gplf_pkg::DIM_W-1:0]              rows_reg;
    logic [gplf_pkg::DIM_W-1:0]              cols_reg;
    logic signed [gplf_pkg::SAMPLE_BITS-1:0] above_row [gplf_pkg::MAX_COLS];
    logic signed [gplf_pkg::SAMPLE_BITS-1:0] two_above_row [gplf_pkg::MAX_COLS];
    logic signed [gplf_pkg::SAMPLE_BITS-1:0] left_val;
    logic signed [gplf_pkg::SAMPLE_BITS-1:0] mid_val;
    logic signed [gplf_pkg::SAMPLE_BITS-1:0] right_val;
    int unsigned                             row_pos;
    int unsigned                             col_pos;
    logic [gplf_pkg::TOTAL_W-1:0]            peak_tally;
    gplf_pkg::t_result                       pending[$];
    int unsigned                             mismatches;

    function new();
        rows_reg   = gplf_pkg::DIM_W'(2);
        cols_reg   = gplf_pkg::DIM_W'(2);
        foreach (above_row[i]) begin
            above_row[i]     = '0;
            two_above_row[i] = '0;
        end
        left_val   = '0;
        mid_val    = '0;
        right_val  = '0;
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        row_pos    = 0;
        col_pos    = 0;
        peak_tally = '0;
    endfunction

    // Sizes outside the supported range are pulled back to it.
    function int unsigned usable(input logic [gplf_pkg::DIM_W-1:0] v, input int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function int unsigned rows_now();
        return usable(rows_reg, gplf_pkg::MAX_ROWS);
    endfunction

    function int unsigned cols_now();
        return usable(cols_reg, gplf_pkg::MAX_COLS);
    endfunction

    // Any size write starts a new frame; the line stores keep their contents.
    function void set_dim(input logic idx, input logic [31:0] word);
        if (idx == gplf_pkg::REG_ROWS) begin
            rows_reg = word[gplf_pkg::DIM_W-1:0];
        end else begin
            cols_reg = word[gplf_pkg::DIM_W-1:0];
        end
        restart();
    endfunction

    function void log_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endfunction

    // One accepted input transaction: judge the cell above it (or the last-row cell for a
    // flush), then shift the new sample into the line stores.
    function void accept_item(input logic op, input logic signed [gplf_pkg::SAMPLE_BITS-1:0] s);
        int unsigned       nr;
        int unsigned       nc;
        int unsigned       c;
        int unsigned       jr;
        logic              is_flush;
        logic              hold;
        gplf_pkg::t_result r;
        nr       = rows_now();
        nc       = cols_now();
        is_flush = (op == gplf_pkg::OP_FLUSH);
        c        = (col_pos >= nc) ? 0 : col_pos;
        // Samples past the grid and flushes inside it are dropped without a trace.
        if (!is_flush && row_pos >= nr) return;
        if (is_flush && row_pos < nr) return;
        if (row_pos > 0) begin
            jr      = is_flush ? nr - 1 : row_pos - 1;
            mid_val = above_row[c];
            if (c + 1 < nc) begin
                right_val = above_row[c + 1];
            end else begin
                right_val = '0;
            end
            // Ties never disqualify; missing neighbours are not compared.
            hold = 1'b1;
            if (c > 0 && mid_val < left_val) hold = 1'b0;
            if (c + 1 < nc && mid_val < right_val) hold = 1'b0;
            if (jr > 0 && mid_val < two_above_row[c]) hold = 1'b0;
            if (!is_flush && mid_val < s) hold = 1'b0;
            if (hold) begin
                peak_tally++;
                r          = '0;
                r.kind     = gplf_pkg::KIND_PEAK;
                r.peak_row = gplf_pkg::OUT_ROW_W'(jr);
                r.peak_col = gplf_pkg::OUT_COL_W'(c);
                pending    = {pending, r};
            end
            left_val = mid_val;
        end
        if (!is_flush) begin
            two_above_row[c] = above_row[c];
            above_row[c]     = s;
        end
        c++;
        if (c >= nc) begin
            c = 0;
            if (is_flush) begin
                r            = '0;
                r.kind       = gplf_pkg::KIND_TOTAL;
                r.peak_total = peak_tally;
                r.last       = 1'b1;
                pending      = {pending, r};
                restart();
                return;
            end
            row_pos++;
        end
        col_pos = c;
    endfunction

    function void check_result(input gplf_pkg::t_result got);
        gplf_pkg::t_result want;
        if (pending.size() == 0) begin
            log_mismatch($sformatf("unexpected result kind=%0d row=%0d col=%0d total=%0d last=%0d",
                got.kind, got.peak_row, got.peak_col, got.peak_total, got.last));
            return;
        end
        want = pending.pop_front();
        if (got.kind != want.kind || got.peak_row != want.peak_row ||
                got.peak_col != want.peak_col || got.peak_total != want.peak_total ||
                got.last != want.last) begin
            log_mismatch($sformatf(
                "expected kind=%0d row=%0d col=%0d total=%0d last=%0d, got %0d %0d %0d %0d %0d",
                want.kind, want.peak_row, want.peak_col, want.peak_total, want.last,
                got.kind, got.peak_row, got.peak_col, got.peak_total, got.last));
        end
    endfunction
endclass

module testbench;

    // How random grids are filled: full-range values, a narrow band that makes ties
    // common, or only the extreme codes.
    typedef enum int {FILL_WIDE, FILL_NARROW, FILL_EDGES} t_fill;
    // Which size registers a phase rewrites.
    typedef enum int {WRITE_BOTH, WRITE_ROWS, WRITE_COLS} t_dim_write;

    localparam int unsigned RANDOM_ITEMS  = 450;
    // Cycles to let the pipeline empty after the last owed result; the block judges a
    // cell in the cycle after its neighbourhood is complete and then queues the result.
    localparam int unsigned SETTLE_CYCLES = 8;
    // Cycles without any transaction on either channel before the run is declared hung.
    localparam int unsigned STALL_LIMIT   = 1000;

    logic                                     i_clk = 1'b0;
    logic                                     i_rst_n;
    logic                                     i_in_valid;
    logic                                     o_in_ready;
    logic                                     i_opcode;
    logic signed [gplf_pkg::SAMPLE_BITS-1:0]  i_sample;
    logic                                     o_out_valid;
    logic                                     i_out_ready = 1'b1;
    logic                                     o_kind;
    logic [gplf_pkg::OUT_ROW_W-1:0]           o_peak_row;
    logic [gplf_pkg::OUT_COL_W-1:0]           o_peak_col;
    logic [gplf_pkg::TOTAL_W-1:0]             o_peak_total;
    logic                                     o_last;
    logic                                     psel;
    logic                                     penable;
    logic                                     pwrite;
    logic [gplf_pkg::APB_ADDR_W-1:0]          paddr;
    logic [gplf_pkg::APB_DATA_W-1:0]          pwdata;
    logic [gplf_pkg::APB_DATA_W-1:0]          prdata;
    logic                                     pready;

    peak_ledger  ledger;
    // When set, neither side inserts idle cycles.
    bit          calm = 1'b0;
    int unsigned fed_items = 0;
    int unsigned sink_stall = 0;
    int unsigned quiet_cycles = 0;

    // The result fields gathered in the same order as the package's result record.
    wire gplf_pkg::t_result seen_result = {o_kind, o_peak_row, o_peak_col, o_peak_total, o_last};

    grid_local_peak_finder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_peak_row   (o_peak_row),
        .o_peak_col   (o_peak_col),
        .o_peak_total (o_peak_total),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Every transaction is observed at the rising edge, before the block's registers
    // move. The result check comes first; a result can never belong to an input that
    // is accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                ledger.check_result(seen_result);
            end
            if (i_in_valid && o_in_ready) begin
                ledger.accept_item(i_opcode, i_sample);
            end
        end
    end

    // Hang detector: any transaction on either data channel resets the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The result side stalls in random bursts unless the phase is calm.
    always @(negedge i_clk) begin
        if (sink_stall != 0) begin
            sink_stall  <= sink_stall - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            sink_stall  <= $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic signed [gplf_pkg::SAMPLE_BITS-1:0] pick_sample(input t_fill fill);
        logic signed [gplf_pkg::SAMPLE_BITS-1:0] v;
        case (fill)
            FILL_NARROW: begin
                v = gplf_pkg::SAMPLE_BITS'(int'($urandom_range(0, 4)) - 2);
            end
            FILL_EDGES: begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh7FFF;
                    1: v = 16'sh8000;
                    2: v = -16'sd1;
                    default: v = '0;
                endcase
            end
            default: begin
                v = gplf_pkg::SAMPLE_BITS'($urandom());
            end
        endcase
        return v;
    endfunction

    // Mostly small grids, now and then a size below the minimum or a wider one.
    function automatic int unsigned pick_dim();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 14) return $urandom_range(2, 8);
        if (roll < 17) return $urandom_range(0, 1);
        return $urandom_range(9, 24);
    endfunction

    // Offers one input transaction and holds it until accepted. Called and returns at a
    // falling edge; valid stays high so the next call can follow back to back.
    task automatic send_item(input logic op, input logic signed [gplf_pkg::SAMPLE_BITS-1:0] value);
        bit took;
        if (!calm && $urandom_range(0, 9) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_opcode   = op;
        i_sample   = value;
        do begin
            @(posedge i_clk);
            took = o_in_ready;
            @(negedge i_clk);
        end while (!took);
    endtask

    // Writes one size register, then reads it back; the read returns the stored bits.
    task automatic write_reg(input logic idx, input logic [31:0] word);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = word;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        ledger.set_dim(idx, word);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata != 32'(word[gplf_pkg::DIM_W-1:0])) begin
            ledger.log_mismatch($sformatf("register %0d read back %0h, expected %0h",
                idx, prdata, word[gplf_pkg::DIM_W-1:0]));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Lets every owed result come out, then gives the pipeline time to finish items
    // that owe nothing.
    task automatic settle_block();
        i_in_valid = 1'b0;
        while (ledger.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Resizes the grid while the block is idle. With dirty set, the unused upper bits of
    // the write data carry noise.
    task automatic set_grid(input int unsigned rows, input int unsigned cols,
                            input t_dim_write which, input bit dirty);
        logic [31:0] word;
        settle_block();
        if (which != WRITE_COLS) begin
            word = dirty ? $urandom() : 32'd0;
            word[gplf_pkg::DIM_W-1:0] = rows[gplf_pkg::DIM_W-1:0];
            write_reg(gplf_pkg::REG_ROWS, word);
        end
        if (which != WRITE_ROWS) begin
            word = dirty ? $urandom() : 32'd0;
            word[gplf_pkg::DIM_W-1:0] = cols[gplf_pkg::DIM_W-1:0];
            write_reg(gplf_pkg::REG_COLS, word);
        end
    endtask

    // Streams one frame at the current size: the grid, then one flush per column. A cut
    // frame stops early and is abandoned by the next size write. Stray items (a flush
    // inside the grid, a sample after it) are dropped by the block and are not counted.
    task automatic run_frame(input t_fill fill, input bit cut_short, input bit stray);
        int unsigned nr;
        int unsigned nc;
        int unsigned grid_len;
        int unsigned stop_at;
        nr       = ledger.rows_now();
        nc       = ledger.cols_now();
        grid_len = nr * nc;
        stop_at  = cut_short ? $urandom_range(1, grid_len + nc - 1) : grid_len + nc;
        for (int unsigned k = 0; k < stop_at; k++) begin
            if (stray && (k == grid_len || $urandom_range(0, 24) == 0)) begin
                send_item(k < grid_len ? gplf_pkg::OP_FLUSH : gplf_pkg::OP_SAMPLE,
                          pick_sample(FILL_WIDE));
            end
            send_item(k < grid_len ? gplf_pkg::OP_SAMPLE : gplf_pkg::OP_FLUSH, pick_sample(fill));
            fed_items++;
        end
    endtask

    initial begin
        ledger      = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_opcode    = gplf_pkg::OP_SAMPLE;
        i_sample    = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames at the reset size of 2 x 2. The first frame opens with a flush
        // that arrives before the grid and has a sample after the grid; both must be
        // dropped. The two opposite corners hold the largest code and are the only peaks.
        send_item(gplf_pkg::OP_FLUSH, 16'sh1234);
        send_item(gplf_pkg::OP_SAMPLE, 16'sh7FFF);
        send_item(gplf_pkg::OP_SAMPLE, 16'sh8000);
        send_item(gplf_pkg::OP_SAMPLE, 16'sh8000);
        send_item(gplf_pkg::OP_SAMPLE, 16'sh7FFF);
        send_item(gplf_pkg::OP_SAMPLE, 16'sh0F0F);
        send_item(gplf_pkg::OP_FLUSH, 16'sh7FFF);
        send_item(gplf_pkg::OP_FLUSH, 16'sh8000);

        // A flat frame of minus one: equal neighbours never disqualify, so every cell
        // is a peak.
        repeat (4) send_item(gplf_pkg::OP_SAMPLE, -16'sd1);
        repeat (2) send_item(gplf_pkg::OP_FLUSH, 16'sh0000);

        // A 3 x 3 hill: only the centre cell wins, the edges and corners lose to it or
        // to their edge neighbours.
        set_grid(3, 3, WRITE_BOTH, 1'b0);
        send_item(gplf_pkg::OP_SAMPLE, 16'sd0);
        send_item(gplf_pkg::OP_SAMPLE, 16'sd1);
        send_item(gplf_pkg::OP_SAMPLE, 16'sd0);
        send_item(gplf_pkg::OP_SAMPLE, 16'sd1);
        send_item(gplf_pkg::OP_SAMPLE, 16'sd5);
        send_item(gplf_pkg::OP_SAMPLE, 16'sd1);
        send_item(gplf_pkg::OP_SAMPLE, 16'sd0);
        send_item(gplf_pkg::OP_SAMPLE, 16'sd1);
        send_item(gplf_pkg::OP_SAMPLE, 16'sd0);
        repeat (3) send_item(gplf_pkg::OP_FLUSH, 16'sh5A5A);

        // Random frames of assorted small sizes. Some phases run without idling, some
        // frames are cut off and restarted by the next size write, and some carry items
        // of the wrong kind.
        while (fed_items < RANDOM_ITEMS) begin
            set_grid(pick_dim(), pick_dim(),
                     ($urandom_range(0, 5) < 4) ? WRITE_BOTH :
                     ($urandom_range(0, 1) == 0) ? WRITE_ROWS : WRITE_COLS,
                     $urandom_range(0, 3) == 0);
            calm = ($urandom_range(0, 3) == 0);
            run_frame(t_fill'($urandom_range(0, 2)), $urandom_range(0, 9) == 0,
                      $urandom_range(0, 3) == 0);
        end

        // A wide frame after a zero row count, which is pulled up to two rows, with
        // stray items mixed in. Then oversized size writes, read back as written, that
        // the closing frames replace before any item arrives.
        calm = 1'b0;
        set_grid(0, 200, WRITE_BOTH, 1'b1);
        run_frame(FILL_WIDE, 1'b0, 1'b1);
        set_grid(2047, 2047, WRITE_BOTH, 1'b1);

        // The closing frames run with both sides at full rate.
        calm = 1'b1;
        set_grid(4, 5, WRITE_BOTH, 1'b0);
        run_frame(FILL_WIDE, 1'b0, 1'b0);
        set_grid(3, 2, WRITE_BOTH, 1'b0);
        run_frame(FILL_NARROW, 1'b0, 1'b0);
        settle_block();

        if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/gplf_pkg.sv
hdl/gplf_res_queue.sv
hdl/grid_local_peak_finder.sv
hdl/gplf_checker.sv
tb/testbench.sv
